@@ hdl/mme_pkg.sv @@
// Package for the matrix multiply engine: widths, codes and shared structs.
// No dependencies; imported by every module of the block.
package mme_pkg;

    localparam int MAX_DIM_DEF = 8;
    localparam int ELEM_W      = 32;
    localparam int DIM_W       = 4;
    localparam int IDX_W       = 3;
    localparam int PROD_W      = 2 * ELEM_W;
    localparam int ACC_W       = PROD_W + 3;
    localparam int FRAC_W      = 16;
    localparam int ACT_W       = 2;
    localparam int CFG_IDX_W   = 2;

    localparam logic [ACT_W-1:0] ACT_LOAD_A  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_LOAD_B  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_COMPUTE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_DIM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_B    = 2'd2;

    typedef enum logic [1:0] {
        OP_LOAD_A  = 2'd0,
        OP_LOAD_B  = 2'd1,
        OP_COMPUTE = 2'd2
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [ELEM_W-1:0]  element;
    } t_cmd;

    typedef struct packed {
        logic             vld;
        logic             first;
        logic             last;
        logic             fin;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } t_tap;

endpackage

@@ hdl/mme_front.sv @@
// Front end: accepts start transactions, classifies the action, queues commands for known actions.
// Depends on mme_pkg.
module mme_front
    import mme_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [ACT_W-1:0]  i_action,
    input  logic [ELEM_W-1:0] i_element,
    output logic              o_busy,
    input  logic              i_pop,
    output logic              o_cmd_vld,
    output t_cmd              o_cmd
);

    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       accept, push, pop, known;
    t_op        op;

    always_comb begin
        known = 1'b1;
        op    = OP_LOAD_A;
        case (i_action)
            ACT_LOAD_A:  op = OP_LOAD_A;
            ACT_LOAD_B:  op = OP_LOAD_B;
            ACT_COMPUTE: op = OP_COMPUTE;
            default:     known = 1'b0;
        endcase
    end

    assign o_busy    = (r_cnt == 2'd2);
    assign accept    = i_start && !o_busy;
    assign push      = accept && known;
    assign o_cmd_vld = (r_cnt != 2'd0);
    assign pop       = i_pop && o_cmd_vld;
    assign o_cmd     = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp].op      <= op;
            r_q[r_wp].element <= i_element;
        end
    end

endmodule

@@ hdl/mme_mac.sv @@
// Multiply-accumulate datapath: product, accumulate, floor shift and saturation.
// Depends on mme_pkg.
module mme_mac
    import mme_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_tap                     i_tap,
    input  logic signed [ELEM_W-1:0] i_a,
    input  logic signed [ELEM_W-1:0] i_b,
    output logic                     o_strobe,
    output logic [ELEM_W-1:0]        o_product_value,
    output logic [IDX_W-1:0]         o_result_row,
    output logic [IDX_W-1:0]         o_result_col,
    output logic                     o_saturated,
    output logic                     o_last
);

    t_tap                     r_p_tap, r_acc_tap;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc, n_acc, shifted;
    logic                     sat;
    logic [ELEM_W-1:0]        val;

    always_comb begin
        n_acc = (r_p_tap.first ? '0 : r_acc) + ACC_W'(r_prod);
        shifted = r_acc >>> FRAC_W;
        sat = (shifted[ACC_W-1:ELEM_W-1] != '0) && (shifted[ACC_W-1:ELEM_W-1] != '1);
        if (!sat) val = shifted[ELEM_W-1:0];
        else if (shifted[ACC_W-1]) val = {1'b1, {(ELEM_W-1){1'b0}}};
        else val = {1'b0, {(ELEM_W-1){1'b1}}};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_tap.vld   <= 1'b0;
            r_acc_tap.vld <= 1'b0;
            o_strobe      <= 1'b0;
        end else begin
            r_p_tap.vld   <= i_tap.vld;
            r_acc_tap.vld <= r_p_tap.vld;
            o_strobe      <= r_acc_tap.vld && r_acc_tap.last;
        end
        r_p_tap.first <= i_tap.first;
        r_p_tap.last  <= i_tap.last;
        r_p_tap.fin   <= i_tap.fin;
        r_p_tap.row   <= i_tap.row;
        r_p_tap.col   <= i_tap.col;
        r_prod        <= PROD_W'(i_a) * PROD_W'(i_b);
        r_acc_tap.first <= r_p_tap.first;
        r_acc_tap.last  <= r_p_tap.last;
        r_acc_tap.fin   <= r_p_tap.fin;
        r_acc_tap.row   <= r_p_tap.row;
        r_acc_tap.col   <= r_p_tap.col;
        if (r_p_tap.vld) r_acc <= n_acc;
        o_product_value <= val;
        o_saturated     <= sat;
        o_result_row    <= r_acc_tap.row;
        o_result_col    <= r_acc_tap.col;
        o_last          <= r_acc_tap.fin;
    end

endmodule

@@ hdl/mme_back.sv @@
// Back end: operand stores, fill pointers and the compute sequencer feeding the MAC.
// Depends on mme_pkg and mme_mac.
module mme_back
    import mme_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
)(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [DIM_W-1:0]  i_nr,
    input  logic [DIM_W-1:0]  i_nk,
    input  logic [DIM_W-1:0]  i_nc,
    input  logic              i_cmd_vld,
    input  t_cmd              i_cmd,
    output logic              o_pop,
    output logic              o_strobe,
    output logic [ELEM_W-1:0] o_product_value,
    output logic [IDX_W-1:0]  o_result_row,
    output logic [IDX_W-1:0]  o_result_col,
    output logic              o_saturated,
    output logic              o_last
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FW    = $clog2(DEPTH + 1);
    localparam int CW    = 2 * IDX_W + 1;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } t_state;

    t_state            r_state;
    logic [ELEM_W-1:0] r_mem_a [DEPTH];
    logic [ELEM_W-1:0] r_mem_b [DEPTH];
    logic [DEPTH-1:0]  r_vld_a, r_vld_b;
    logic [FW-1:0]     r_fill_a, r_fill_b;
    logic [IDX_W-1:0]  r_i, r_j, r_k;
    logic [ELEM_W-1:0] r_a_dat, r_b_dat;
    logic              r_a_vld, r_b_vld;
    t_tap              r_tap;
    logic              we_a, we_b, k_end, j_end, i_end, issue, take;
    logic [FW-1:0]     lim_a, lim_b;
    logic [CW-1:0]     addr_a_full, addr_b_full;
    logic [AW-1:0]     addr_a, addr_b;
    logic signed [ELEM_W-1:0] op_a, op_b;

    assign o_pop = (r_state == ST_IDLE);
    assign take  = o_pop && i_cmd_vld;
    assign issue = (r_state == ST_RUN);
    assign lim_a = FW'(i_nr) * FW'(i_nk);
    assign lim_b = FW'(i_nk) * FW'(i_nc);
    assign we_a  = take && (i_cmd.op == OP_LOAD_A) && (r_fill_a < lim_a);
    assign we_b  = take && (i_cmd.op == OP_LOAD_B) && (r_fill_b < lim_b);
    assign k_end = ({1'b0, r_k} == i_nk - 4'd1);
    assign j_end = ({1'b0, r_j} == i_nc - 4'd1);
    assign i_end = ({1'b0, r_i} == i_nr - 4'd1);
    assign addr_a_full = CW'(r_i) * CW'(i_nk) + CW'(r_k);
    assign addr_b_full = CW'(r_k) * CW'(i_nc) + CW'(r_j);
    assign addr_a = addr_a_full[AW-1:0];
    assign addr_b = addr_b_full[AW-1:0];
    assign op_a = r_a_vld ? r_a_dat : '0;
    assign op_b = r_b_vld ? r_b_dat : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_fill_a <= '0;
            r_fill_b <= '0;
            r_vld_a  <= '0;
            r_vld_b  <= '0;
            r_i      <= '0;
            r_j      <= '0;
            r_k      <= '0;
            r_tap.vld <= 1'b0;
        end else begin
            r_tap.vld <= issue;
            if (we_a) begin
                r_vld_a[r_fill_a[AW-1:0]] <= 1'b1;
                r_fill_a <= r_fill_a + FW'(1);
            end
            if (we_b) begin
                r_vld_b[r_fill_b[AW-1:0]] <= 1'b1;
                r_fill_b <= r_fill_b + FW'(1);
            end
            case (r_state)
                ST_IDLE: begin
                    if (take && (i_cmd.op == OP_COMPUTE)) begin
                        r_i     <= '0;
                        r_j     <= '0;
                        r_k     <= '0;
                        r_state <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (!k_end) begin
                        r_k <= r_k + IDX_W'(1);
                    end else begin
                        r_k <= '0;
                        if (!j_end) begin
                            r_j <= r_j + IDX_W'(1);
                        end else begin
                            r_j <= '0;
                            if (!i_end) begin
                                r_i <= r_i + IDX_W'(1);
                            end else begin
                                r_fill_a <= '0;
                                r_fill_b <= '0;
                                r_state  <= ST_IDLE;
                            end
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
        r_tap.first <= (r_k == '0);
        r_tap.last  <= k_end;
        r_tap.fin   <= k_end && j_end && i_end;
        r_tap.row   <= r_i;
        r_tap.col   <= r_j;
    end

    always_ff @(posedge i_clk) begin
        if (we_a) r_mem_a[r_fill_a[AW-1:0]] <= i_cmd.element;
        r_a_dat <= r_mem_a[addr_a];
    end

    always_ff @(posedge i_clk) begin
        if (we_b) r_mem_b[r_fill_b[AW-1:0]] <= i_cmd.element;
        r_b_dat <= r_mem_b[addr_b];
    end

    always_ff @(posedge i_clk) begin
        r_a_vld <= r_vld_a[addr_a];
        r_b_vld <= r_vld_b[addr_b];
    end

    mme_mac u_mac (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_tap           (r_tap),
        .i_a             (op_a),
        .i_b             (op_b),
        .o_strobe        (o_strobe),
        .o_product_value (o_product_value),
        .o_result_row    (o_result_row),
        .o_result_col    (o_result_col),
        .o_saturated     (o_saturated),
        .o_last          (o_last)
    );

endmodule

@@ hdl/matrix_multiply_engine_core.sv @@
// Top level of the matrix multiply engine: dimension registers, front end, back end.
// Depends on mme_pkg, mme_front, mme_back.
//
// Channel   Direction  Handshake                   Payload
// command   in         i_start, o_busy             i_action, i_element
// result    out        o_strobe (one cycle)        o_product_value, o_result_row,
//                                                  o_result_col, o_saturated, o_last
// config    in         i_cfg_we                    i_cfg_idx, i_cfg_data
//
// The back end takes a load whenever it is idle; a two-entry command queue absorbs bursts.
// A compute forms rows_a*cols_b*inner_dim products on the single MAC (512 at 8x8x8).
// Each result strobes once the last of its inner_dim products has been accumulated.
// Reset is synchronous; stores read as zero until written.
// The receiver cannot stall; o_busy is high only while the command queue is full.
module matrix_multiply_engine_core
    import mme_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
)(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    output logic                 o_busy,
    input  logic [ACT_W-1:0]     i_action,
    input  logic [ELEM_W-1:0]    i_element,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [DIM_W-1:0]     i_cfg_data,
    output logic                 o_strobe,
    output logic [ELEM_W-1:0]    o_product_value,
    output logic [IDX_W-1:0]     o_result_row,
    output logic [IDX_W-1:0]     o_result_col,
    output logic                 o_saturated,
    output logic                 o_last
);

    logic [DIM_W-1:0] r_rows_a, r_inner_dim, r_cols_b;
    logic [DIM_W-1:0] nr, nk, nc;
    logic             cmd_vld, pop;
    t_cmd             cmd;

    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0) r = DIM_W'(1);
        else if (v > DIM_W'(MAX_DIM)) r = DIM_W'(MAX_DIM);
        else r = v;
        return r;
    endfunction

    assign nr = eff_dim(r_rows_a);
    assign nk = eff_dim(r_inner_dim);
    assign nc = eff_dim(r_cols_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_a    <= DIM_W'(8);
            r_inner_dim <= DIM_W'(8);
            r_cols_b    <= DIM_W'(8);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ROWS_A:    r_rows_a    <= i_cfg_data;
                CFG_INNER_DIM: r_inner_dim <= i_cfg_data;
                CFG_COLS_B:    r_cols_b    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    mme_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_start),
        .i_action  (i_action),
        .i_element (i_element),
        .o_busy    (o_busy),
        .i_pop     (pop),
        .o_cmd_vld (cmd_vld),
        .o_cmd     (cmd)
    );

    mme_back #(
        .MAX_DIM (MAX_DIM)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_nr            (nr),
        .i_nk            (nk),
        .i_nc            (nc),
        .i_cmd_vld       (cmd_vld),
        .i_cmd           (cmd),
        .o_pop           (pop),
        .o_strobe        (o_strobe),
        .o_product_value (o_product_value),
        .o_result_row    (o_result_row),
        .o_result_col    (o_result_col),
        .o_saturated     (o_saturated),
        .o_last          (o_last)
    );

endmodule

@@ hdl/mme_checker.sv @@
// Port-level checker for the matrix multiply engine, bound to the top level.
// Depends on mme_pkg and matrix_multiply_engine_core.
module mme_checker
    import mme_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_start,
    input logic              o_busy,
    input logic              o_strobe,
    input logic [ELEM_W-1:0] o_product_value,
    input logic              o_saturated
);

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_strobe && !o_busy)
        else $error("outputs active after reset");

    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_saturated |->
            (o_product_value == 32'h7fffffff) || (o_product_value == 32'h80000000))
        else $error("saturated result not at a range limit");

    a_busy_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_busy) |-> $past(i_start))
        else $error("busy rose without a transaction");

endmodule

bind matrix_multiply_engine_core mme_checker u_mme_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_start         (i_start),
    .o_busy          (o_busy),
    .o_strobe        (o_strobe),
    .o_product_value (o_product_value),
    .o_saturated     (o_saturated)
);
